>>> rtl/ppt_pkg.sv
// ppt_pkg: shared types, constants and the range clip helper for the page permission tracker
// depends on nothing; used by ppt_ram users, the top level and the checker
package ppt_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int PTR_W      = IDX_W + 1;
    localparam int PG_W       = 32 - PAGE_SHIFT + 1;

    localparam logic [2:0] FN_MAP    = 3'd0;
    localparam logic [2:0] FN_UNMAP  = 3'd1;
    localparam logic [2:0] FN_MOVE   = 3'd2;
    localparam logic [2:0] FN_EXISTS = 3'd3;
    localparam logic [2:0] FN_QUERY  = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] address;
        logic [30:0] length;
        logic [31:0] src_address;
        logic [30:0] old_length;
        logic        perm_read;
        logic        perm_write;
        logic        perm_exec;
    } request_t;

    typedef struct packed {
        logic        answer;
        logic [23:0] region_start;
        logic [24:0] region_end;
        logic        protections_differ;
        logic        out_of_range;
    } result_t;

    typedef struct packed {
        logic ro;
        logic rw;
        logic ex;
        logic ever_ro;
        logic ever_rw;
    } marks_t;

    typedef struct packed {
        logic             empty;
        logic             oor;
        logic [PTR_W-1:0] first;
        logic [PTR_W-1:0] stop;
    } clip_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_DAT, ST_OLDSET, ST_NEWSET, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MD_WRITE, MD_UNMAP, MD_SAMPLE, MD_OLD, MD_EXISTS, MD_QCHK, MD_QFWD, MD_QBACK
    } mode_t;

    // first page and exclusive stop page of a byte range, clipped to the table
    function automatic clip_t clip_range(input logic [31:0] a, input logic [30:0] l);
        logic [PG_W-1:0] pg;
        logic [PG_W-1:0] cnt;
        logic [PG_W-1:0] sum;
        clip_t c;
        pg  = PG_W'(a >> PAGE_SHIFT);
        cnt = PG_W'((33'(l) + 33'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
        sum = pg + cnt;
        c.oor   = 1'b0;
        c.empty = (cnt == '0);
        c.first = PTR_W'(pg);
        c.stop  = PTR_W'(sum);
        if (!c.empty) begin
            if (pg >= PG_W'(NUM_PAGES)) begin
                c.oor   = 1'b1;
                c.empty = 1'b1;
            end else if (sum > PG_W'(NUM_PAGES)) begin
                c.oor  = 1'b1;
                c.stop = PTR_W'(NUM_PAGES);
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/page_permission_tracker_unit.sv
// page_permission_tracker_unit: per-page permission marks with range walks
// depends on ppt_pkg and ppt_ram
//
// One command transfer is taken when start is high and busy is low; busy stays high until
// the single result shows on result for one cycle with done high, and the receiver must take
// it then. After reset the mark memory is swept to zero, one page a cycle, and busy stays high
// until all NUM_PAGES (4096) pages are cleared. A command walks its pages through one
// read-modify-write port of the mark memory, a read state then a data state per page, so one
// page is finished before the next is read: map and unmap walk their range, move samples the
// source page, clears the source range (skipped when the source lies beyond the table) and
// writes the new range, exists reads one page, and the read-only query checks each page and
// then visits each page of the surrounding extent. The memory port is what limits the walk.
module page_permission_tracker_unit
    import ppt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    state_t           state_reg, state_next;
    mode_t            mode_reg, mode_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [PTR_W-1:0] stop_reg, stop_next;
    logic [PTR_W-1:0] first_reg, first_next;
    logic             mro_reg, mro_next, mrw_reg, mrw_next, mex_reg, mex_next;
    request_t         req_reg, req_next;
    result_t          res_reg, res_next;

    // mark memory port
    logic             we, re;
    logic [IDX_W-1:0] waddr, raddr;
    marks_t           wdata, rdata;

    ppt_ram #(.WIDTH($bits(marks_t)), .DEPTH(NUM_PAGES)) u_marks (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // range decode of the incoming command and of the latched move ranges
    clip_t            clip_in, clip_old, clip_new;
    logic [PG_W-1:0]  lo_pg, hi_pg;
    logic [32:0]      span_end;
    logic             ro_now;
    logic [PTR_W-1:0] ptr_inc, ptr_dec;

    assign clip_in  = clip_range(request.address, request.length);
    assign clip_old = clip_range(req_reg.src_address, req_reg.old_length);
    assign clip_new = clip_range(req_reg.address, req_reg.length);
    assign lo_pg    = PG_W'(request.address >> PAGE_SHIFT);
    // zero length counts as one byte
    assign span_end = 33'(request.address) + 33'(request.length)
                    - ((request.length == '0) ? 33'd0 : 33'd1);
    assign hi_pg    = PG_W'(span_end >> PAGE_SHIFT);
    assign ro_now   = rdata.ro & ~rdata.ever_rw;
    assign ptr_inc  = ptr_reg + PTR_W'(1);
    assign ptr_dec  = ptr_reg - PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            mode_reg  <= MD_WRITE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            ptr_reg   <= ptr_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        stop_reg  <= stop_next;
        first_reg <= first_next;
        mro_reg   <= mro_next;
        mrw_reg   <= mrw_next;
        mex_reg   <= mex_next;
        req_reg   <= req_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        ptr_next   = ptr_reg;
        stop_next  = stop_reg;
        first_next = first_reg;
        mro_next   = mro_reg;
        mrw_next   = mrw_reg;
        mex_next   = mex_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = ptr_reg[IDX_W-1:0];
        raddr      = ptr_reg[IDX_W-1:0];
        wdata      = rdata;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep the mark memory to zero after reset
                we       = 1'b1;
                wdata    = '0;
                ptr_next = ptr_inc;
                if (ptr_inc == PTR_W'(NUM_PAGES))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                res_next = '0;
                if (start)
                begin
                    req_next = request;
                    priority case (request.func)
                        FN_MAP, FN_UNMAP:
                        begin
                            mode_next     = (request.func == FN_MAP) ? MD_WRITE : MD_UNMAP;
                            mro_next      = request.perm_read & ~request.perm_write;
                            mrw_next      = request.perm_read & request.perm_write;
                            mex_next      = request.perm_exec;
                            ptr_next      = clip_in.first;
                            stop_next     = clip_in.stop;
                            res_next.out_of_range = clip_in.oor;
                            state_next    = clip_in.empty ? ST_DONE : ST_RD;
                        end
                        FN_MOVE:
                        begin
                            mro_next = 1'b0;
                            mrw_next = 1'b0;
                            mex_next = 1'b0;
                            if (PG_W'(request.src_address >> PAGE_SHIFT) < PG_W'(NUM_PAGES))
                            begin
                                mode_next  = MD_SAMPLE;
                                ptr_next   = PTR_W'(request.src_address >> PAGE_SHIFT);
                                state_next = ST_RD;
                            end
                            else
                            begin
                                res_next.out_of_range = 1'b1;
                                state_next = ST_OLDSET;
                            end
                        end
                        FN_EXISTS:
                        begin
                            if (lo_pg < PG_W'(NUM_PAGES))
                            begin
                                mode_next  = MD_EXISTS;
                                ptr_next   = PTR_W'(lo_pg);
                                state_next = ST_RD;
                            end
                            else
                            begin
                                res_next.out_of_range = 1'b1;
                                state_next = ST_DONE;
                            end
                        end
                        FN_QUERY:
                        begin
                            if (hi_pg >= PG_W'(NUM_PAGES))
                            begin
                                res_next.out_of_range = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                mode_next       = MD_QCHK;
                                ptr_next        = PTR_W'(lo_pg);
                                first_next      = PTR_W'(lo_pg);
                                stop_next       = PTR_W'(hi_pg) + PTR_W'(1);
                                res_next.answer = 1'b1;
                                state_next      = ST_RD;
                            end
                        end
                        default:
                        begin
                            // unused function codes answer all zero
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                re         = 1'b1;
                state_next = ST_DAT;
            end

            ST_OLDSET:
            begin
                // source range of a move: clear its ro and rw marks, compare against the sampled page
                res_next.out_of_range = res_reg.out_of_range | clip_old.oor;
                mode_next  = MD_OLD;
                ptr_next   = clip_old.first;
                first_next = clip_old.first;
                stop_next  = clip_old.stop;
                state_next = clip_old.empty ? ST_NEWSET : ST_RD;
            end

            ST_NEWSET:
            begin
                res_next.out_of_range = res_reg.out_of_range | clip_new.oor;
                mode_next  = MD_WRITE;
                ptr_next   = clip_new.first;
                stop_next  = clip_new.stop;
                state_next = clip_new.empty ? ST_DONE : ST_RD;
            end

            ST_DAT:
            begin
                unique case (mode_reg)
                    MD_WRITE, MD_UNMAP, MD_OLD:
                    begin
                        we = 1'b1;
                        if (mode_reg == MD_WRITE)
                        begin
                            wdata.ro      = mro_reg;
                            wdata.rw      = mrw_reg;
                            wdata.ex      = mex_reg;
                            wdata.ever_ro = rdata.ever_ro | mro_reg;
                            wdata.ever_rw = rdata.ever_rw | mrw_reg;
                        end
                        else
                        begin
                            wdata.ro = 1'b0;
                            wdata.rw = 1'b0;
                        end
                        if (mode_reg == MD_OLD && ptr_reg != first_reg
                            && (rdata.ro != mro_reg || rdata.rw != mrw_reg
                                || rdata.ex != mex_reg))
                        begin
                            res_next.protections_differ = 1'b1;
                        end
                        ptr_next = ptr_inc;
                        if (ptr_inc == stop_reg)
                        begin
                            state_next = (mode_reg == MD_OLD) ? ST_NEWSET : ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_RD;
                        end
                    end

                    MD_SAMPLE:
                    begin
                        mro_next   = rdata.ro;
                        mrw_next   = rdata.rw;
                        mex_next   = rdata.ex;
                        state_next = ST_OLDSET;
                    end

                    MD_EXISTS:
                    begin
                        res_next.answer = rdata.ro | rdata.rw | rdata.ex;
                        state_next      = ST_DONE;
                    end

                    MD_QCHK, MD_QFWD:
                    begin
                        if (mode_reg == MD_QCHK && !ro_now)
                        begin
                            res_next.answer = 1'b0;
                            state_next      = ST_DONE;
                        end
                        else if (mode_reg == MD_QFWD && !ro_now)
                        begin
                            // extent ends before this page: scan backward unless at page zero
                            res_next.region_end = 25'({ptr_reg, PAGE_SHIFT'(0)});
                            if (first_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                mode_next  = MD_QBACK;
                                ptr_next   = first_reg - PTR_W'(1);
                                state_next = ST_RD;
                            end
                        end
                        else
                        begin
                            ptr_next   = ptr_inc;
                            state_next = ST_RD;
                            mode_next  = (ptr_inc == stop_reg) ? MD_QFWD : mode_reg;
                            if ((mode_reg == MD_QFWD || ptr_inc == stop_reg)
                                && ptr_inc == PTR_W'(NUM_PAGES))
                            begin
                                // forward scan hit the table end
                                res_next.region_end = 25'({ptr_inc, PAGE_SHIFT'(0)});
                                if (first_reg == '0)
                                begin
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    mode_next = MD_QBACK;
                                    ptr_next  = first_reg - PTR_W'(1);
                                end
                            end
                        end
                    end

                    MD_QBACK:
                    begin
                        if (!ro_now)
                        begin
                            res_next.region_start = 24'({ptr_inc, PAGE_SHIFT'(0)});
                            state_next = ST_DONE;
                        end
                        else if (ptr_reg == '0)
                        begin
                            res_next.region_start = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ptr_next   = ptr_dec;
                            state_next = ST_RD;
                        end
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign result = res_reg;

endmodule

>>> rtl/ppt_ram.sv
// ppt_ram: generic single write, single read ram with registered read data
// depends on nothing
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ppt_checker.sv
// ppt_checker: port-level assertions for page_permission_tracker_unit, with its bind
// depends on ppt_pkg
module ppt_checker
    import ppt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input request_t request,
    input logic     busy,
    input logic     done,
    input result_t  result
);

    // a result strobe lasts exactly one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // an accepted command makes the unit busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    // results only appear while a command is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result without a command in flight");

    // extent fields stay zero without a positive answer
    a_region_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.answer) |-> (result.region_start == '0 && result.region_end == '0))
        else $error("region reported without a positive answer");

endmodule

bind page_permission_tracker_unit ppt_checker u_ppt_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
